### rtl/core/mbrr_pkg.sv
// Shared types, constants and CRC helper for the Modbus read-registers master.
`default_nettype none

package mbrr_pkg;

   localparam int MAX_REGISTERS = 16;
   localparam int FRAME_BYTES   = 37;
   // longest frame is 2*MAX_REGISTERS+5 bytes; the count must hold that value
   localparam int CNT_W         = $clog2(2 * MAX_REGISTERS + 6);
   localparam int ADDR_W        = $clog2(FRAME_BYTES);

   localparam logic [7:0]  FUNC_READ = 8'h03;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [2:0]  TX_LAST_IDX = 3'd7;

   typedef enum logic {
      OP_REQUEST = 1'b0,
      OP_RX      = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_TX     = 2'd0,
      KIND_VALUE  = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_CRC   = 2'd1,
      STAT_FUNC  = 2'd2,
      STAT_COUNT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TX,
      S_STATUS,
      S_RD_HI,
      S_RD_LO,
      S_VAL
   } state_type;

   typedef struct packed {
      logic start_req;
      logic rx_byte;
      logic load_tx;
      logic load_status;
      logic rd_hi;
      logic rd_lo;
      logic load_val;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic tx_last;
      logic rx_done;
      logic status_ok;
      logic n_zero;
      logic val_last;
   } stat_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/core/mbrr_ctrl.sv
// Sequencing state machine: accepts items and steps the datapath through each run.
`default_nettype none

module mbrr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_opcode,
   input  wire mbrr_pkg::stat_type stat,
   output mbrr_pkg::cmd_type       cmd
);
   import mbrr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_REQUEST) begin
                  cmd.start_req = 1'b1;
                  state_in      = S_TX;
               end else begin
                  cmd.rx_byte = 1'b1;
                  if (stat.rx_done) state_in = S_STATUS;
               end
            end
         end
         S_TX: begin
            if (stat.out_free) begin
               cmd.load_tx = 1'b1;
               if (stat.tx_last) state_in = S_IDLE;
            end
         end
         S_STATUS: begin
            if (stat.out_free) begin
               cmd.load_status = 1'b1;
               state_in = (stat.status_ok && !stat.n_zero) ? S_RD_HI : S_IDLE;
            end
         end
         S_RD_HI: begin
            cmd.rd_hi = 1'b1;
            state_in  = S_RD_LO;
         end
         S_RD_LO: begin
            cmd.rd_lo = 1'b1;
            state_in  = S_VAL;
         end
         S_VAL: begin
            if (stat.out_free) begin
               cmd.load_val = 1'b1;
               state_in = stat.val_last ? S_IDLE : S_RD_HI;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/mbrr_datapath.sv
// Request latch, frame buffer, CRC unit, frame checks and the result register.
`default_nettype none

module mbrr_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mbrr_pkg::cmd_type cmd,
   output mbrr_pkg::stat_type     stat,
   input  wire logic [7:0]        req_slave_address,
   input  wire logic [15:0]       req_start_register,
   input  wire logic [4:0]        req_register_count,
   input  wire logic [7:0]        req_sensor_index,
   input  wire logic [7:0]        req_rx_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_tx_byte,
   output logic [7:0]             rsp_slot,
   output logic [3:0]             rsp_register_index,
   output logic [15:0]            rsp_register_value,
   output logic [1:0]             rsp_status,
   output logic                   rsp_seen_online,
   output logic                   rsp_last
);
   import mbrr_pkg::*;

   // latched request and receive state
   logic [7:0]       addr_ff;
   logic [4:0]       n_ff;
   logic [7:0]       slot_ff;
   logic [15:0]      start_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [15:0]      crc_ff;
   logic [7:0]       prev_ff;
   logic [7:0]       func_ff;
   logic [7:0]       bc_ff;
   status_type       status_ff;
   logic [2:0]       tx_idx_ff;
   logic [3:0]       val_idx_ff;
   logic [7:0]       hi_ff;
   logic [7:0]       mem_q_ff;

   logic [7:0] frame_mem [FRAME_BYTES];

   // result register
   logic       rsp_valid_ff;
   kind_type   kind_ff;
   logic [7:0] tx_byte_ff;
   logic [7:0] rsp_slot_ff;
   logic [3:0] reg_idx_ff;
   logic [15:0] reg_val_ff;
   status_type rsp_status_ff;
   logic       online_ff;
   logic       last_ff;

   logic [4:0]        n_sat;
   logic [CNT_W-1:0]  flen;
   logic [CNT_W-1:0]  body;
   logic [CNT_W-1:0]  cnt_in;
   logic              addr_miss;
   logic              frame_done;
   logic [7:0]        tx_byte;
   logic [15:0]       crc_base;
   logic [7:0]        crc_data;
   logic [15:0]       crc_in;
   status_type        status_in;
   logic [ADDR_W-1:0] rd_addr;

   always_comb begin
      n_sat = (req_register_count > 5'(MAX_REGISTERS)) ? 5'(MAX_REGISTERS)
                                                       : req_register_count;
      flen       = CNT_W'({n_ff, 1'b0}) + CNT_W'(5);
      body       = CNT_W'({n_ff, 1'b0}) + CNT_W'(3);
      cnt_in     = cnt_ff + CNT_W'(1);
      addr_miss  = (cnt_ff == '0) && (req_rx_byte != addr_ff);
      frame_done = !addr_miss && (cnt_in >= flen);

      case (tx_idx_ff)
         3'd0:    tx_byte = addr_ff;
         3'd1:    tx_byte = FUNC_READ;
         3'd2:    tx_byte = start_ff[15:8];
         3'd3:    tx_byte = start_ff[7:0];
         3'd4:    tx_byte = 8'h00;
         3'd5:    tx_byte = {3'b000, n_ff};
         3'd6:    tx_byte = crc_ff[7:0];
         default: tx_byte = crc_ff[15:8];
      endcase

      // one CRC unit shared by the request and the received frame
      if (cmd.load_tx) begin
         crc_base = crc_ff;
         crc_data = tx_byte;
      end else begin
         crc_base = (cnt_ff == '0) ? CRC_INIT : crc_ff;
         crc_data = req_rx_byte;
      end
      crc_in = crc_update(crc_base, crc_data);

      // the final byte is the CRC high byte; the one before it is the low byte
      if (func_ff != FUNC_READ) begin
         status_in = STAT_FUNC;
      end else if (bc_ff != {2'b00, n_ff, 1'b0}) begin
         status_in = STAT_COUNT;
      end else if (crc_ff != {req_rx_byte, prev_ff}) begin
         status_in = STAT_CRC;
      end else begin
         status_in = STAT_OK;
      end

      rd_addr = cmd.rd_lo ? ADDR_W'({val_idx_ff, 1'b0}) + ADDR_W'(4)
                          : ADDR_W'({val_idx_ff, 1'b0}) + ADDR_W'(3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         n_ff       <= '0;
         slot_ff    <= '0;
         cnt_ff     <= '0;
         tx_idx_ff  <= '0;
         val_idx_ff <= '0;
      end else begin
         if (cmd.start_req) begin
            addr_ff   <= req_slave_address;
            n_ff      <= n_sat;
            slot_ff   <= req_sensor_index;
            cnt_ff    <= '0;
            tx_idx_ff <= '0;
         end
         if (cmd.rx_byte) begin
            cnt_ff <= (addr_miss || frame_done) ? '0 : cnt_in;
         end
         if (cmd.load_tx) tx_idx_ff <= tx_idx_ff + 3'd1;
         if (cmd.load_status) val_idx_ff <= '0;
         if (cmd.load_val) val_idx_ff <= val_idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_req) begin
         start_ff <= req_start_register;
         crc_ff   <= CRC_INIT;
      end
      if (cmd.load_tx && tx_idx_ff < 3'd6) crc_ff <= crc_in;
      if (cmd.rx_byte) begin
         prev_ff   <= req_rx_byte;
         status_ff <= status_in;
         if (cnt_ff < body) crc_ff <= crc_in;
         if (cnt_ff == CNT_W'(1)) func_ff <= req_rx_byte;
         if (cnt_ff == CNT_W'(2)) bc_ff <= req_rx_byte;
         if (cnt_ff < CNT_W'(FRAME_BYTES)) frame_mem[cnt_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
      if (cmd.rd_hi || cmd.rd_lo) mem_q_ff <= frame_mem[rd_addr];
      if (cmd.rd_lo) hi_ff <= mem_q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_tx || cmd.load_status || cmd.load_val) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // capture the slot with the beat so a new request cannot disturb a waiting beat
   always_ff @(posedge clock) begin
      if (cmd.load_tx) begin
         kind_ff       <= KIND_TX;
         tx_byte_ff    <= tx_byte;
         rsp_slot_ff   <= slot_ff;
         reg_idx_ff    <= '0;
         reg_val_ff    <= '0;
         rsp_status_ff <= STAT_OK;
         online_ff     <= 1'b0;
         last_ff       <= (tx_idx_ff == TX_LAST_IDX);
      end else if (cmd.load_status) begin
         kind_ff       <= KIND_STATUS;
         tx_byte_ff    <= '0;
         rsp_slot_ff   <= slot_ff;
         reg_idx_ff    <= '0;
         reg_val_ff    <= '0;
         rsp_status_ff <= status_ff;
         online_ff     <= (status_ff != STAT_FUNC);
         last_ff       <= (status_ff != STAT_OK) || (n_ff == '0);
      end else if (cmd.load_val) begin
         kind_ff       <= KIND_VALUE;
         tx_byte_ff    <= '0;
         rsp_slot_ff   <= slot_ff;
         reg_idx_ff    <= val_idx_ff;
         reg_val_ff    <= {hi_ff, mem_q_ff};
         rsp_status_ff <= STAT_OK;
         online_ff     <= 1'b1;
         last_ff       <= stat.val_last;
      end
   end

   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign stat.tx_last   = (tx_idx_ff == TX_LAST_IDX);
   assign stat.rx_done   = frame_done;
   assign stat.status_ok = (status_ff == STAT_OK);
   assign stat.n_zero    = (n_ff == '0);
   assign stat.val_last  = (({1'b0, val_idx_ff} + 5'd1) == n_ff);

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_tx_byte        = tx_byte_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_register_index = reg_idx_ff;
   assign rsp_register_value = reg_val_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_seen_online    = online_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

### rtl/core/modbus_read_registers_master.sv
// Top level of the Modbus RTU read-holding-registers master.
// A request beat is accepted and then yields the eight request bytes
// (CRC low byte first), one beat per cycle while rsp_ready stays high;
// the request CRC is folded in as each byte is loaded into the result register.
// A received-byte beat yields nothing until the frame of 2n+5 bytes is
// complete; the final byte then gives a status beat, and with an ok status
// n register values follow, each read from the single-port frame buffer
// as a high and a low byte on two reads. The block takes no new beat until the
// last result of a run is loaded; that last beat may still wait at the output
// while the next beat is accepted.
`default_nettype none

module modbus_read_registers_master (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_slave_address,
   input  wire logic [15:0] req_start_register,
   input  wire logic [4:0]  req_register_count,
   input  wire logic [7:0]  req_sensor_index,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_tx_byte,
   output logic [7:0]       rsp_slot,
   output logic [3:0]       rsp_register_index,
   output logic [15:0]      rsp_register_value,
   output logic [1:0]       rsp_status,
   output logic             rsp_seen_online,
   output logic             rsp_last
);
   import mbrr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mbrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   mbrr_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_slave_address  (req_slave_address),
      .req_start_register (req_start_register),
      .req_register_count (req_register_count),
      .req_sensor_index   (req_sensor_index),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_slot           (rsp_slot),
      .rsp_register_index (rsp_register_index),
      .rsp_register_value (rsp_register_value),
      .rsp_status         (rsp_status),
      .rsp_seen_online    (rsp_seen_online),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

### rtl/core/mbrr_checker.sv
// Port-level checks for the read-registers master, bound to the top level.
`default_nettype none

module mbrr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic [7:0]  rsp_slot,
   input wire logic [3:0]  rsp_register_index,
   input wire logic [15:0] rsp_register_value,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_seen_online,
   input wire logic        rsp_last
);
   import mbrr_pkg::*;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_tx_byte)
         && $stable(rsp_slot) && $stable(rsp_register_index)
         && $stable(rsp_register_value) && $stable(rsp_status)
         && $stable(rsp_seen_online) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // no new input while a run still has results to come
   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input accepted in the middle of a run");

   // register values only follow a clean frame
   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_VALUE |-> rsp_seen_online && rsp_status == STAT_OK)
      else $error("register value with a bad frame status");

   // a wrong function code never counts as online
   a_func_offline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS && rsp_status == STAT_FUNC
         |-> !rsp_seen_online && rsp_last)
      else $error("function code error reported online or not last");

endmodule

bind modbus_read_registers_master mbrr_checker u_mbrr_checker (.*);

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the Modbus read-holding-registers master.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mbrr_pkg::*;

   typedef struct {
      logic       hold_off;
      opcode_type op;
      logic [7:0] addr;
      logic [15:0] start;
      logic [4:0] count;
      logic [7:0] sensor;
      logic [7:0] rx;
   } req_beat_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] tx_byte;
      logic [7:0] slot;
      logic [3:0] reg_idx;
      logic [15:0] value;
      status_type status;
      logic       online;
      logic       last;
   } reply_type;

   typedef enum int {FR_GOOD, FR_BAD_CRC, FR_BAD_FUNC, FR_BAD_COUNT, FR_SHORT} frame_fault_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   opcode_type  req_opcode = OP_REQUEST;
   logic [7:0]  req_slave_address = 8'h00;
   logic [15:0] req_start_register = 16'h0000;
   logic [4:0]  req_register_count = 5'd0;
   logic [7:0]  req_sensor_index = 8'h00;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_tx_byte;
   logic [7:0]  rsp_slot;
   logic [3:0]  rsp_register_index;
   logic [15:0] rsp_register_value;
   logic [1:0]  rsp_status;
   logic        rsp_seen_online;
   logic        rsp_last;

   modbus_read_registers_master uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_slave_address(req_slave_address),
      .req_start_register(req_start_register),
      .req_register_count(req_register_count),
      .req_sensor_index(req_sensor_index),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_slot(rsp_slot),
      .rsp_register_index(rsp_register_index),
      .rsp_register_value(rsp_register_value),
      .rsp_status(rsp_status),
      .rsp_seen_online(rsp_seen_online),
      .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   req_beat_type beats_to_send[$];
   reply_type    replies_due[$];
   int planned_beats = 0;
   int launched_beats = 0;
   int taken_beats = 0;
   int mismatches = 0;
   int requests_seen = 0;
   int rx_bytes_seen = 0;
   int reports_seen = 0;
   int values_seen = 0;
   logic steady;

   // master state as the bus sees it
   logic [7:0] rx_frame [0:FRAME_BYTES-1];
   int         rx_count = 0;
   logic [7:0] want_addr = 8'h00;
   int         want_regs = 0;
   logic [7:0] cur_slot = 8'h00;

   // no random idling on either side for a stretch in the middle of the run
   assign steady = (taken_beats >= 100) && (taken_beats < 170);

   function automatic logic [15:0] crc16_modbus_step(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic logic [7:0] frame_byte(int i);
      return (i < FRAME_BYTES) ? rx_frame[i] : 8'h00;
   endfunction

   function automatic void add_reply(kind_type kind, logic [7:0] tx, logic [3:0] idx,
                                     logic [15:0] val, status_type st, logic online,
                                     logic last);
      reply_type r;
      r.kind = kind;
      r.tx_byte = tx;
      r.slot = cur_slot;
      r.reg_idx = idx;
      r.value = val;
      r.status = st;
      r.online = online;
      r.last = last;
      replies_due.push_back(r);
   endfunction

   // one accepted beat: update the master state and queue the replies it causes
   function automatic void modbus_master_step(opcode_type op, logic [7:0] addr,
                                              logic [15:0] start, logic [4:0] count,
                                              logic [7:0] sensor, logic [7:0] rx);
      logic [7:0]  req [0:7];
      logic [15:0] crc;
      logic [15:0] got;
      int n, flen, body, k;
      if (op == OP_REQUEST) begin
         n = (count > MAX_REGISTERS) ? MAX_REGISTERS : count;
         want_addr = addr;
         want_regs = n;
         cur_slot = sensor;
         rx_count = 0;
         req[0] = addr;
         req[1] = FUNC_READ;
         req[2] = start[15:8];
         req[3] = start[7:0];
         req[4] = 8'h00;
         req[5] = 8'(n);
         crc = CRC_INIT;
         for (k = 0; k < 6; k++) crc = crc16_modbus_step(crc, req[k]);
         req[6] = crc[7:0];
         req[7] = crc[15:8];
         for (k = 0; k < 8; k++) add_reply(KIND_TX, req[k], 4'd0, 16'd0, STAT_OK, 1'b0, k == 7);
         return;
      end
      if (rx_count < FRAME_BYTES) rx_frame[rx_count] = rx;
      rx_count++;
      if (frame_byte(0) != want_addr) begin
         rx_count = 0;
         return;
      end
      flen = 2 * want_regs + 5;
      if (rx_count < flen) return;
      rx_count = 0;
      if (frame_byte(1) != FUNC_READ) begin
         add_reply(KIND_STATUS, 8'h00, 4'd0, 16'd0, STAT_FUNC, 1'b0, 1'b1);
         return;
      end
      if (frame_byte(2) != 8'(2 * want_regs)) begin
         add_reply(KIND_STATUS, 8'h00, 4'd0, 16'd0, STAT_COUNT, 1'b1, 1'b1);
         return;
      end
      body = 2 * want_regs + 3;
      crc = CRC_INIT;
      for (k = 0; k < body; k++) crc = crc16_modbus_step(crc, frame_byte(k));
      got = {frame_byte(body + 1), frame_byte(body)};
      if (crc != got) begin
         add_reply(KIND_STATUS, 8'h00, 4'd0, 16'd0, STAT_CRC, 1'b1, 1'b1);
         return;
      end
      add_reply(KIND_STATUS, 8'h00, 4'd0, 16'd0, STAT_OK, 1'b1, want_regs == 0);
      for (k = 0; k < want_regs; k++)
         add_reply(KIND_VALUE, 8'h00, 4'(k), {frame_byte(3 + 2 * k), frame_byte(4 + 2 * k)},
                   STAT_OK, 1'b1, k + 1 == want_regs);
   endfunction

   function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      end
   endfunction

   // accept side and result monitor
   always @(posedge clock) begin
      reply_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result beat, kind %0h slot %0h", $time, rsp_kind,
                        rsp_slot);
            end else begin
               want = replies_due.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("tx_byte", want.tx_byte, rsp_tx_byte);
               check_field("slot", want.slot, rsp_slot);
               check_field("register_index", want.reg_idx, rsp_register_index);
               check_field("register_value", want.value, rsp_register_value);
               check_field("status", want.status, rsp_status);
               check_field("seen_online", want.online, rsp_seen_online);
               check_field("last", want.last, rsp_last);
               if (want.kind == KIND_STATUS) reports_seen++;
               if (want.kind == KIND_VALUE) values_seen++;
            end
         end
         if (req_valid && req_ready) begin
            taken_beats++;
            if (req_opcode == OP_REQUEST) requests_seen++;
            else rx_bytes_seen++;
            modbus_master_step(req_opcode, req_slave_address, req_start_register,
                               req_register_count, req_sensor_index, req_rx_byte);
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      req_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && taken_beats != launched_beats)) begin
         if (beats_to_send.size() == 0) begin
            req_valid <= 1'b0;
         end else if (beats_to_send[0].hold_off) begin
            // hold until every pending result has drained
            req_valid <= 1'b0;
            if (replies_due.size() == 0) void'(beats_to_send.pop_front());
         end else if (!steady && $urandom_range(99, 0) < 10) begin
            req_valid <= 1'b0;
         end else begin
            b = beats_to_send.pop_front();
            req_valid <= 1'b1;
            req_opcode <= b.op;
            req_slave_address <= b.addr;
            req_start_register <= b.start;
            req_register_count <= b.count;
            req_sensor_index <= b.sensor;
            req_rx_byte <= b.rx;
            launched_beats++;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= steady || ($urandom_range(99, 0) >= 10);
   end

   function automatic void push_beat(opcode_type op, logic [7:0] addr, logic [15:0] start,
                                     logic [4:0] count, logic [7:0] sensor, logic [7:0] rx);
      req_beat_type b;
      b.hold_off = 1'b0;
      b.op = op;
      b.addr = addr;
      b.start = start;
      b.count = count;
      b.sensor = sensor;
      b.rx = rx;
      beats_to_send.push_back(b);
      planned_beats++;
   endfunction

   function automatic void push_request(logic [7:0] addr, logic [15:0] start,
                                        logic [4:0] count, logic [7:0] sensor);
      push_beat(OP_REQUEST, addr, start, count, sensor, 8'($urandom));
   endfunction

   // unused request fields carry random bits on received-byte beats
   function automatic void push_rx(logic [7:0] data);
      push_beat(OP_RX, 8'($urandom), 16'($urandom), 5'($urandom), 8'($urandom), data);
   endfunction

   function automatic void push_hold_off();
      req_beat_type b;
      b.hold_off = 1'b1;
      b.op = OP_REQUEST;
      b.addr = 8'h00;
      b.start = 16'h0000;
      b.count = 5'd0;
      b.sensor = 8'h00;
      b.rx = 8'h00;
      beats_to_send.push_back(b);
   endfunction

   function automatic logic [7:0] other_than(logic [7:0] x);
      return x ^ 8'($urandom_range(255, 1));
   endfunction

   function automatic logic [4:0] pick_count();
      int r;
      r = $urandom_range(99, 0);
      if (r < 70) return 5'($urandom_range(4, 0));
      if (r < 85) return 5'($urandom_range(15, 5));
      if (r < 95) return 5'(MAX_REGISTERS);
      return 5'($urandom_range(31, 17));
   endfunction

   // slave response of n registers, with an optional fault; send only the first keep bytes
   function automatic void push_frame(logic [7:0] addr, int n, frame_fault_type fault,
                                      int keep);
      logic [7:0]  fb [0:FRAME_BYTES-1];
      logic [15:0] crc;
      int len, k;
      len = 2 * n + 5;
      fb[0] = addr;
      fb[1] = (fault == FR_BAD_FUNC) ? other_than(FUNC_READ) : FUNC_READ;
      fb[2] = (fault == FR_BAD_COUNT) ? other_than(8'(2 * n)) : 8'(2 * n);
      for (k = 3; k < 2 * n + 3; k++) fb[k] = 8'($urandom);
      crc = CRC_INIT;
      for (k = 0; k < 2 * n + 3; k++) crc = crc16_modbus_step(crc, fb[k]);
      fb[2 * n + 3] = crc[7:0];
      fb[2 * n + 4] = crc[15:8];
      if (fault == FR_BAD_CRC) begin
         k = $urandom_range(len - 1, 3);
         fb[k] = fb[k] ^ (8'h01 << $urandom_range(7, 0));
      end
      for (k = 0; k < keep && k < len; k++) push_rx(fb[k]);
   endfunction

   initial begin
      logic [7:0] addr;
      logic [4:0] cnt;
      int n, r, len;
      bit mid_pause;
      frame_fault_type fault;
      mid_pause = 1'b0;

      // stray byte and a zero-count frame before any request: address 0 applies
      push_rx(8'hA5);
      push_frame(8'h00, 0, FR_GOOD, 5);
      push_request(8'h5A, 16'h0000, 5'd0, 8'h00);
      push_frame(8'h5A, 0, FR_BAD_COUNT, 5);
      // count above the maximum saturates
      push_request(8'hFF, 16'hFFFF, 5'd31, 8'hFF);
      push_request(8'hFF, 16'hFFFF, 5'd1, 8'hFF);
      push_rx(8'h00);
      push_frame(8'hFF, 1, FR_BAD_FUNC, 7);
      push_hold_off();

      while (planned_beats < 200) begin
         if (!mid_pause && planned_beats >= 130) begin
            push_hold_off();
            mid_pause = 1'b1;
         end
         r = $urandom_range(99, 0);
         if (r < 75) begin
            addr = 8'($urandom);
            cnt = pick_count();
            n = (cnt > MAX_REGISTERS) ? MAX_REGISTERS : cnt;
            len = 2 * n + 5;
            push_request(addr, 16'($urandom), cnt, 8'($urandom));
            if ($urandom_range(9, 0) == 0) push_rx(other_than(addr));
            r = $urandom_range(99, 0);
            if (r < 60) fault = FR_GOOD;
            else if (r < 75) fault = FR_BAD_CRC;
            else if (r < 85) fault = FR_BAD_FUNC;
            else if (r < 95) fault = FR_BAD_COUNT;
            else fault = FR_SHORT;
            push_frame(addr, n, fault, (fault == FR_SHORT) ? $urandom_range(len - 1, 1) : len);
         end else if (r < 88) begin
            repeat ($urandom_range(3, 1)) push_rx(8'($urandom));
         end else begin
            push_request(8'($urandom), 16'($urandom), pick_count(), 8'($urandom));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (beats_to_send.size() != 0 || taken_beats != launched_beats ||
             replies_due.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (replies_due.size() != 0) begin
         mismatches += replies_due.size();
         $display("%0t: %0d expected results never arrived", $time, replies_due.size());
      end
      $display("Drove %0d read requests and %0d bus bytes; checked %0d frame reports",
               requests_seen, rx_bytes_seen, reports_seen);
      $display("and %0d register values, with %0d field mismatches.", values_seen, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #400us;
      $display("%0t: timeout", $time);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
